### rtl/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    // Queue sizing and time quantum.
    localparam int QUEUE_DEPTH = 16;
    localparam int QUANTUM     = 1000;
    localparam int MAX_RESULTS = 16;

    // Field widths.
    localparam int DL_W    = 52;
    localparam int ID_W    = 16;
    localparam int ENTRY_W = DL_W + ID_W;

    // Derived widths.
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
    localparam int REM_W   = $clog2(QUANTUM + 1);

    // Rounding unit: remainder is built four input bits per cycle.
    localparam int DIGIT_W     = 4;
    localparam int ROUND_STEPS = (DL_W + DIGIT_W - 1) / DIGIT_W;
    localparam int SHIFT_W     = ROUND_STEPS * DIGIT_W;
    localparam int STEP_W      = $clog2(ROUND_STEPS + 1);

    localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};

    // Input item kinds.
    localparam logic [1:0] KIND_SCHED = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_FIRED    = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_STOPPED  = 3'd3;
    localparam logic [2:0] ST_RELEASED = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    // Write port of the entry memory.
    typedef struct packed {
        logic               en;
        logic [PTR_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

    // Ring index: a + b modulo the queue depth, with a + b below twice the depth.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, a} + {1'b0, b};
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

### rtl/deadline_timer_queue.sv
`timescale 1ns / 1ps

// Deadline timer queue. Entries are kept sorted by rounded deadline in a
// ring held in a 16-entry memory with a registered read port. A schedule
// first rounds its deadline up to the quantum (four bits of remainder per
// cycle, then one add), then checks for a stopped or full queue, then for
// each entry it is compared against on its way down the sorted order does a
// memory read, then a compare and move, and last writes the new entry and
// loads its result. A tick or stop reads the head, then decides, for each
// fired or released task, and closes the run when the queue runs empty, the
// result limit is reached, or the scan stops at an entry not yet due. The
// block takes one item at a time: s_tready is high only while the sequencer
// is idle between items. Each result is one transfer on the master side,
// held in an output register, so a result left waiting on m_tready stalls
// the sequencer.
module deadline_timer_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,   // task_id[15:0], deadline[67:16], now[119:68]
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // status[2:0], out_task_id[18:3], out_deadline[70:19]
    output logic         m_tlast
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_ROUND    = 8'b00000010,
        S_DECIDE   = 8'b00000100,
        S_INS_RD   = 8'b00001000,
        S_INS_CMP  = 8'b00010000,
        S_INS_PUT  = 8'b00100000,
        S_SCAN_RD  = 8'b01000000,
        S_SCAN_CMP = 8'b10000000
    } state_t;

    state_t                         state_reg, state_next;
    logic                           flush_reg, flush_next;
    logic [dtq_pkg::PTR_W-1:0]      head_reg, head_next;
    logic [dtq_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [dtq_pkg::CNT_W-1:0]      pos_reg, pos_next;
    logic                           stopped_reg, stopped_next;
    logic                           is_stop_reg, is_stop_next;
    logic [dtq_pkg::NRES_W-1:0]     nres_reg, nres_next;
    logic [dtq_pkg::ID_W-1:0]       task_reg, task_next;
    logic [dtq_pkg::DL_W-1:0]       dl_reg, dl_next;
    logic [dtq_pkg::DL_W-1:0]       now_reg, now_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [dtq_pkg::ENTRY_W-1:0]    pend_reg, pend_next;
    logic                           m_valid_reg, m_valid_next;
    logic [71:0]                    m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    dtq_pkg::ram_wr_t               wr;
    logic                           rd_en;
    logic [dtq_pkg::PTR_W-1:0]      rd_addr;
    logic [dtq_pkg::ENTRY_W-1:0]    rd_data;
    logic [dtq_pkg::DL_W-1:0]       rd_dl;
    logic                           round_start;
    logic                           round_done;
    logic [dtq_pkg::DL_W-1:0]       round_dout;
    logic                           out_free;
    logic                           s_fire;
    logic [2:0]                     run_status;

    dtq_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (round_start),
        .din     (s_tdata[67:16]),
        .done    (round_done),
        .dout    (round_dout)
    );

    dtq_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_dl      = rd_data[dtq_pkg::ENTRY_W-1:dtq_pkg::ID_W];
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE) && !flush_reg;
    assign s_fire     = s_tvalid && s_tready;
    assign run_status = is_stop_reg ? dtq_pkg::ST_RELEASED : dtq_pkg::ST_FIRED;

    // Sequencer: sorted insert by read-compare-move, and head scan for ticks and stops.
    always_comb begin
        state_next      = state_reg;
        flush_next      = flush_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        stopped_next    = stopped_reg;
        is_stop_next    = is_stop_reg;
        nres_next       = nres_reg;
        task_next       = task_reg;
        dl_next         = dl_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        wr              = '0;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        round_start     = 1'b0;

        if (flush_reg) begin
            // Close a tick or stop run with its final result.
            if (out_free) begin
                m_valid_next = 1'b1;
                m_last_next  = 1'b1;
                if (pend_valid_reg) begin
                    m_data_next = {1'b0, pend_reg, run_status};
                end else if (is_stop_reg) begin
                    m_data_next = {1'b0, {dtq_pkg::ENTRY_W{1'b0}}, dtq_pkg::ST_RELEASED};
                end else begin
                    m_data_next = {1'b0, {dtq_pkg::ENTRY_W{1'b0}}, dtq_pkg::ST_NONE};
                end
                if (is_stop_reg) begin
                    count_next = '0;
                end
                pend_valid_next = 1'b0;
                flush_next      = 1'b0;
                state_next      = S_IDLE;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        unique case (s_tuser) inside
                            dtq_pkg::KIND_SCHED: begin
                                task_next   = s_tdata[15:0];
                                round_start = 1'b1;
                                state_next  = S_ROUND;
                            end
                            dtq_pkg::KIND_TICK, dtq_pkg::KIND_STOP: begin
                                is_stop_next    = (s_tuser == dtq_pkg::KIND_STOP);
                                if (s_tuser == dtq_pkg::KIND_STOP) begin
                                    stopped_next = 1'b1;
                                end
                                now_next        = s_tdata[119:68];
                                nres_next       = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_SCAN_RD;
                            end
                            default: begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
                S_ROUND: begin
                    if (round_done) begin
                        dl_next    = round_dout;
                        state_next = S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (stopped_reg
                        || count_reg == dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH)) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_last_next  = 1'b1;
                            m_data_next  = {1'b0, dl_reg, task_reg,
                                            stopped_reg ? dtq_pkg::ST_STOPPED
                                                        : dtq_pkg::ST_FULL};
                            state_next   = S_IDLE;
                        end
                    end else begin
                        pos_next   = count_reg;
                        state_next = (count_reg == '0) ? S_INS_PUT : S_INS_RD;
                    end
                end
                S_INS_RD: begin
                    rd_en      = 1'b1;
                    rd_addr    = dtq_pkg::wrap_add(head_reg, pos_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
                S_INS_CMP: begin
                    // Move a later entry up one place, or stop at the slot.
                    if (rd_dl > dl_reg) begin
                        wr.en      = 1'b1;
                        wr.addr    = dtq_pkg::wrap_add(head_reg, pos_reg);
                        wr.data    = rd_data;
                        pos_next   = pos_reg - 1'b1;
                        state_next = (pos_reg == dtq_pkg::CNT_W'(1)) ? S_INS_PUT : S_INS_RD;
                    end else begin
                        state_next = S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    if (out_free) begin
                        wr.en        = 1'b1;
                        wr.addr      = dtq_pkg::wrap_add(head_reg, pos_reg);
                        wr.data      = {dl_reg, task_reg};
                        count_next   = count_reg + 1'b1;
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b1;
                        m_data_next  = {1'b0, dl_reg, task_reg, dtq_pkg::ST_ACCEPTED};
                        state_next   = S_IDLE;
                    end
                end
                S_SCAN_RD: begin
                    if (count_reg != '0
                        && nres_reg != dtq_pkg::NRES_W'(dtq_pkg::MAX_RESULTS)) begin
                        rd_en      = 1'b1;
                        state_next = S_SCAN_CMP;
                    end else begin
                        flush_next = 1'b1;
                    end
                end
                S_SCAN_CMP: begin
                    // A due head entry becomes pending; the previous one goes out.
                    if (is_stop_reg || rd_dl <= now_reg) begin
                        if (!pend_valid_reg || out_free) begin
                            if (pend_valid_reg) begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b0;
                                m_data_next  = {1'b0, pend_reg, run_status};
                            end
                            pend_next       = rd_data;
                            pend_valid_next = 1'b1;
                            head_next       = dtq_pkg::wrap_add(head_reg, dtq_pkg::CNT_W'(1));
                            count_next      = count_reg - 1'b1;
                            nres_next       = nres_reg + 1'b1;
                            state_next      = S_SCAN_RD;
                        end
                    end else begin
                        flush_next = 1'b1;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            flush_reg      <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            flush_reg      <= flush_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pos_reg     <= pos_next;
        is_stop_reg <= is_stop_next;
        nres_reg    <= nres_next;
        task_reg    <= task_next;
        dl_reg      <= dl_next;
        now_reg     <= now_next;
        pend_reg    <= pend_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // The fill count never exceeds the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= dtq_pkg::CNT_W'(dtq_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // The memory is only written by the insertion sort.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> (state_reg == S_INS_CMP || state_reg == S_INS_PUT))
        else $error("entry memory written outside insertion");

    // Once stopped, the queue stays stopped until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    // An insertion compare always has a slot below it inside the fill.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_CMP && !flush_reg)
            |-> (pos_reg != '0 && pos_reg <= count_reg))
        else $error("insertion position out of range");

    // A run is only closed out from one of the scan states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> (state_reg == S_SCAN_RD || state_reg == S_SCAN_CMP))
        else $error("run close outside a scan");
`endif

endmodule

### rtl/dtq_round.sv
`timescale 1ns / 1ps

module dtq_round (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [dtq_pkg::DL_W-1:0] din,
    output logic                     done,
    output logic [dtq_pkg::DL_W-1:0] dout
);

    logic                         busy_reg, busy_next;
    logic                         fin_reg, fin_next;
    logic                         done_reg, done_next;
    logic [dtq_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [dtq_pkg::SHIFT_W-1:0]  shift_reg, shift_next;
    logic [dtq_pkg::REM_W-1:0]    rem_reg, rem_next;
    logic [dtq_pkg::DL_W-1:0]     d_reg, d_next;
    logic [dtq_pkg::DL_W-1:0]     dout_reg, dout_next;
    logic [dtq_pkg::REM_W:0]      r;
    logic [dtq_pkg::DL_W:0]       sum;

    // One digit of the remainder per cycle, then one add to round up.
    always_comb begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        dout_next  = dout_reg;
        r          = {1'b0, rem_reg};
        sum        = '0;
        if (start) begin
            busy_next  = 1'b1;
            step_next  = '0;
            rem_next   = '0;
            d_next     = din;
            shift_next = dtq_pkg::SHIFT_W'(din);
        end else if (busy_reg) begin
            for (int i = 0; i < dtq_pkg::DIGIT_W; i++) begin
                r = {r[dtq_pkg::REM_W-1:0], shift_reg[dtq_pkg::SHIFT_W-1-i]};
                if (r >= (dtq_pkg::REM_W + 1)'(dtq_pkg::QUANTUM)) begin
                    r = r - (dtq_pkg::REM_W + 1)'(dtq_pkg::QUANTUM);
                end
            end
            rem_next   = r[dtq_pkg::REM_W-1:0];
            shift_next = shift_reg << dtq_pkg::DIGIT_W;
            step_next  = step_reg + 1'b1;
            if (step_reg == dtq_pkg::STEP_W'(dtq_pkg::ROUND_STEPS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            sum = {1'b0, d_reg} + (dtq_pkg::DL_W + 1)'(dtq_pkg::QUANTUM)
                - (dtq_pkg::DL_W + 1)'(rem_reg);
            if (rem_reg == '0) begin
                dout_next = d_reg;
            end else if (sum[dtq_pkg::DL_W]) begin
                dout_next = dtq_pkg::DL_MAX;
            end else begin
                dout_next = sum[dtq_pkg::DL_W-1:0];
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        d_reg     <= d_next;
        dout_reg  <= dout_next;
    end

    assign done = done_reg;
    assign dout = dout_reg;

endmodule

### rtl/dtq_ram.sv
`timescale 1ns / 1ps

module dtq_ram (
    input  logic                        aclk,
    input  dtq_pkg::ram_wr_t            wr,
    input  logic                        rd_en,
    input  logic [dtq_pkg::PTR_W-1:0]   rd_addr,
    output logic [dtq_pkg::ENTRY_W-1:0] rd_data
);

    logic [dtq_pkg::ENTRY_W-1:0] mem [dtq_pkg::QUEUE_DEPTH];
    logic [dtq_pkg::ENTRY_W-1:0] rd_data_reg;

    // Single write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### verif/deadline_timer_queue_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the timer queue, keeps its own sorted copy of the
// queue, and compares every result transfer with the oldest prediction.
module deadline_timer_queue_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending_count,
    output int           result_count
);

    typedef struct packed {
        logic [2:0]               status;
        logic [dtq_pkg::ID_W-1:0] task_id;
        logic [dtq_pkg::DL_W-1:0] deadline;
        logic                     last;
    } timer_result_t;

    timer_result_t            expected_q[$];
    logic [dtq_pkg::DL_W-1:0] q_deadline[$];
    logic [dtq_pkg::ID_W-1:0] q_task[$];
    bit                       halted;

    // Round up to the next quantum, saturating at the top of the field.
    function automatic logic [dtq_pkg::DL_W-1:0] quantize(
        input logic [dtq_pkg::DL_W-1:0] d);
        logic [63:0] r;
        r = ((64'(d) + dtq_pkg::QUANTUM - 1) / dtq_pkg::QUANTUM) * dtq_pkg::QUANTUM;
        return (r > 64'(dtq_pkg::DL_MAX)) ? dtq_pkg::DL_MAX : r[dtq_pkg::DL_W-1:0];
    endfunction

    function automatic timer_result_t mk(input logic [2:0] st,
                                         input logic [dtq_pkg::ID_W-1:0] id,
                                         input logic [dtq_pkg::DL_W-1:0] dl,
                                         input logic lst);
        timer_result_t r;
        r.status = st; r.task_id = id; r.deadline = dl; r.last = lst;
        return r;
    endfunction

    // Apply one accepted input item to the shadow queue and queue its results.
    task automatic predict_item(input logic [1:0] kind,
                                input logic [dtq_pkg::ID_W-1:0] id,
                                input logic [dtq_pkg::DL_W-1:0] dl_raw,
                                input logic [dtq_pkg::DL_W-1:0] now);
        logic [dtq_pkg::DL_W-1:0] dl;
        int pos;
        int n;
        dl = quantize(dl_raw);
        n = 0;
        if (kind == dtq_pkg::KIND_SCHED) begin
            if (halted) expected_q.push_back(mk(dtq_pkg::ST_STOPPED, id, dl, 1'b1));
            else if (q_task.size() >= dtq_pkg::QUEUE_DEPTH)
                expected_q.push_back(mk(dtq_pkg::ST_FULL, id, dl, 1'b1));
            else begin
                pos = q_task.size();
                while (pos > 0 && q_deadline[pos-1] > dl) pos--;
                q_deadline.insert(pos, dl);
                q_task.insert(pos, id);
                expected_q.push_back(mk(dtq_pkg::ST_ACCEPTED, id, dl, 1'b1));
            end
        end else if (kind == dtq_pkg::KIND_TICK) begin
            while (n < dtq_pkg::MAX_RESULTS && q_task.size() > 0
                   && q_deadline[0] <= now) begin
                expected_q.push_back(mk(dtq_pkg::ST_FIRED, q_task[0], q_deadline[0], 1'b0));
                void'(q_task.pop_front());
                void'(q_deadline.pop_front());
                n++;
            end
            if (n == 0) expected_q.push_back(mk(dtq_pkg::ST_NONE, '0, '0, 1'b1));
            else expected_q[$].last = 1'b1;
        end else if (kind == dtq_pkg::KIND_STOP) begin
            halted = 1'b1;
            while (q_task.size() > 0) begin
                if (n < dtq_pkg::MAX_RESULTS) begin
                    expected_q.push_back(mk(dtq_pkg::ST_RELEASED, q_task[0],
                                            q_deadline[0], 1'b0));
                    n++;
                end
                void'(q_task.pop_front());
                void'(q_deadline.pop_front());
            end
            if (n == 0) expected_q.push_back(mk(dtq_pkg::ST_RELEASED, '0, '0, 1'b1));
            else expected_q[$].last = 1'b1;
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge aclk) begin
        timer_result_t seen;
        timer_result_t want;
        if (!aresetn) begin
            halted = 1'b0;
            expected_q.delete();
            q_deadline.delete();
            q_task.delete();
            fail_count    <= 0;
            result_count  <= 0;
            pending_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata[15:0], s_tdata[67:16], s_tdata[119:68]);
            end
            if (m_tvalid && m_tready) begin
                seen = mk(m_tdata[2:0], m_tdata[18:3], m_tdata[70:19], m_tlast);
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, seen);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) begin
                        $display("%0t: mismatch expected st=%0d id=%h dl=%h last=%b",
                                 $time, want.status, want.task_id, want.deadline, want.last);
                        $display("%0t:          actual   st=%0d id=%h dl=%h last=%b",
                                 $time, seen.status, seen.task_id, seen.deadline, seen.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= expected_q.size();
        end
    end

endmodule

### verif/deadline_timer_queue_tb.sv
`timescale 1ns / 1ps

// Drives schedules, ticks and stops into the timer queue under varying
// back-pressure and reports the verdict from the checker's failure and pending counts.
module deadline_timer_queue_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    int           fail_count;
    int           pending_count;
    int           result_count;
    int           send_idle_pct;
    int           recv_idle_pct;
    bit           hold_off;
    int           cycle_count;
    int           item_count;
    logic [dtq_pkg::DL_W-1:0] base_time;

    deadline_timer_queue u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    deadline_timer_queue_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls, or a long hold-off while the flag is set.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one item, idling beforehand at the current rate, until accepted.
    task automatic send_item(input logic [1:0] kind, input logic [15:0] id,
                             input logic [dtq_pkg::DL_W-1:0] dl,
                             input logic [dtq_pkg::DL_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {now, dl, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [dtq_pkg::DL_W-1:0] rand_wide();
        return dtq_pkg::DL_W'({$urandom(), $urandom()});
    endfunction

    // Random mix: mostly schedules near a moving clock, ticks, rare stops.
    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 55)
                send_item(dtq_pkg::KIND_SCHED, 16'($urandom()),
                          ($urandom_range(9) == 0) ? rand_wide()
                          : base_time + $urandom_range(20000), rand_wide());
            else if (r < 93) begin
                base_time = base_time + $urandom_range(8000);
                send_item(dtq_pkg::KIND_TICK, 16'($urandom()), rand_wide(),
                          ($urandom_range(19) == 0) ? rand_wide() : base_time);
            end else if (r < 96)
                send_item(2'd3, 16'($urandom()), rand_wide(), rand_wide());
            else
                send_item(dtq_pkg::KIND_STOP, 16'($urandom()), rand_wide(), rand_wide());
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = dtq_pkg::KIND_SCHED;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        item_count    = 0;
        base_time     = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, ties, empty tick, full queue with receiver held off.
        send_item(dtq_pkg::KIND_TICK, 16'h0, '0, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'hFFFF, dtq_pkg::DL_MAX, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'h0000, '0, dtq_pkg::DL_MAX);
        send_item(dtq_pkg::KIND_SCHED, 16'h1234, 52'd1, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'h1235, 52'd1000, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'h1236, 52'd999, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'h1237, dtq_pkg::DL_MAX - 52'd1000, '0);
        send_item(2'd3, 16'hAAAA, dtq_pkg::DL_MAX, dtq_pkg::DL_MAX);
        wait_drained();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_item(dtq_pkg::KIND_SCHED, 16'(16'h100 + i),
                          52'(($urandom_range(5)) * 1000), '0);
        join
        send_item(dtq_pkg::KIND_SCHED, 16'hBEEF, 52'd5, '0);
        send_item(dtq_pkg::KIND_TICK, 16'h0, '0, 52'd2000);
        send_item(dtq_pkg::KIND_TICK, 16'h0, '0, dtq_pkg::DL_MAX);
        wait_drained();

        // Random phases under three idle patterns.
        send_idle_pct = 29; recv_idle_pct = 85;
        random_phase(60);
        wait_drained();
        send_idle_pct = 85; recv_idle_pct = 29;
        random_phase(60);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(45);

        // Stop and check that later schedules are turned away.
        send_item(dtq_pkg::KIND_STOP, '0, '0, '0);
        send_item(dtq_pkg::KIND_STOP, '0, '0, '0);
        send_item(dtq_pkg::KIND_SCHED, 16'h5555, 52'd77, '0);
        send_item(dtq_pkg::KIND_TICK, '0, '0, dtq_pkg::DL_MAX);
        wait_drained();
        repeat (100) @(posedge aclk);

        $display("Ran %0d input items producing %0d results, covering full queue,",
                 item_count, result_count);
        $display("saturating deadlines, ties, long output stalls and stop.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
